/* hw/rtl/sbf_pkg.sv */
// Shared constants and types for the spring bond force pipeline.
// Used by sbf_isqrt and spring_bond_force; depends on nothing.
package sbf_pkg;

  localparam int DATA_W = 32;
  localparam int ROOT_W = 32;
  localparam int RAD_W  = 64;
  localparam int DIFF_W = 34;
  localparam int GAIN_W = 38;
  localparam int PROD_W = 72;
  localparam int FORCE_W = 48;
  localparam int EPS_W  = 26;
  localparam int G_W    = 36;

  localparam logic [31:0] S_CUT      = 32'd4252017623;
  localparam logic [31:0] EPS_MAGIC  = 32'd1374389535;
  localparam int          EPS_SHIFT  = 37;
  localparam logic [47:0] POS_MAX    = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_MAG    = 48'h8000_0000_0000;

  localparam logic [31:0] STIFF_RST  = 32'd65536;
  localparam logic [31:0] REST_RST   = 32'd65536;
  localparam logic [31:0] MEXT_RST   = 32'd65536;
  localparam logic [25:0] EPS_RST    = 26'd655;

  typedef enum logic [7:0] {
    REG_FORCE_MODE  = 8'd0,
    REG_STIFFNESS   = 8'd1,
    REG_REST_LENGTH = 8'd2,
    REG_MAX_EXT     = 8'd3
  } cfg_reg_e;

endpackage

/* hw/rtl/sbf_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on sbf_pkg for widths; carries a sideband word alongside each request.
module sbf_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [sbf_pkg::RAD_W-1:0] rad_i,
  input  logic [63:0]               side_i,
  output logic                      vld_o,
  output logic [sbf_pkg::ROOT_W-1:0] root_o,
  output logic [63:0]               side_o
);

  localparam int RW   = sbf_pkg::ROOT_W;
  localparam int REMW = 2 * RW + 2;

  logic [RW-1:0]   vld_q;
  logic [REMW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [63:0]     side_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    localparam int B = RW - 1 - i;
    logic [REMW-1:0] rem_cur;
    logic [REMW-1:0] trial;
    logic [RW-1:0]   root_cur;
    logic [63:0]     side_cur;
    logic            vld_cur;

    if (i == 0) begin : g_first
      assign rem_cur  = REMW'(rad_i);
      assign root_cur = '0;
      assign side_cur = side_i;
      assign vld_cur  = vld_i;
    end else begin : g_next
      assign rem_cur  = rem_q[i-1];
      assign root_cur = root_q[i-1];
      assign side_cur = side_q[i-1];
      assign vld_cur  = vld_q[i-1];
    end

    assign trial = (REMW'(root_cur) << (B + 1)) | (REMW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_cur;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i] <= side_cur;
        if (rem_cur >= trial) begin
          rem_q[i]  <= rem_cur - trial;
          root_q[i] <= root_cur | (RW'(1) << B);
        end else begin
          rem_q[i]  <= rem_cur;
          root_q[i] <= root_cur;
        end
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> rem_q[RW-1] <= {1'b0, root_o, 1'b0})
    else $error("square root remainder exceeds twice the root");
`endif

endmodule

/* hw/rtl/sbf_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in Q_W bits; a sideband word travels with each request.
module sbf_div #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [Q_W-1:0]    vld_q;
  logic [CW-1:0]     rem_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    localparam int B = Q_W - 1 - i;
    logic [CW-1:0]     rem_cur;
    logic [CW-1:0]     dsh;
    logic [DEN_W-1:0]  den_cur;
    logic [Q_W-1:0]    quo_cur;
    logic [SIDE_W-1:0] side_cur;
    logic              vld_cur;

    if (i == 0) begin : g_first
      assign rem_cur  = CW'(num_i);
      assign den_cur  = den_i;
      assign quo_cur  = '0;
      assign side_cur = side_i;
      assign vld_cur  = vld_i;
    end else begin : g_next
      assign rem_cur  = rem_q[i-1];
      assign den_cur  = den_q[i-1];
      assign quo_cur  = quo_q[i-1];
      assign side_cur = side_q[i-1];
      assign vld_cur  = vld_q[i-1];
    end

    assign dsh = CW'(den_cur) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_cur;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i] <= side_cur;
        den_q[i]  <= den_cur;
        if (rem_cur >= dsh) begin
          rem_q[i] <= rem_cur - dsh;
          quo_q[i] <= quo_cur | (Q_W'(1) << B);
        end else begin
          rem_q[i] <= rem_cur;
          quo_q[i] <= quo_cur;
        end
      end
    end
  end

  assign vld_o  = vld_q[Q_W-1];
  assign quo_o  = quo_q[Q_W-1];
  assign side_o = side_q[Q_W-1];

endmodule

/* hw/rtl/spring_bond_force.sv */
// Top level of the spring bond force pipeline with its configuration registers.
// Depends on sbf_pkg, sbf_isqrt and sbf_div.
//
// Usage: each request on the s_axis channel carries one bond displacement
// (disp_x, disp_y). One result per request leaves on the m_axis channel with
// the force components in tdata and the cutoff and saturation flags in tuser.
// The configuration channel writes force_mode, stiffness, rest_length and
// max_extension by index; writes are taken in every cycle and must only be
// issued while no request is in flight.
// A new request is accepted every cycle while the receiver is not stalling.
// The pipeline runs through the 32-stage square root, the 32-stage direction
// dividers and the 36-stage FENE gain divider in series.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
// until the waiting result is taken. Reset empties the pipeline and loads the
// registers with mode 0 and 1.0 for stiffness, rest length and max extension.
module spring_bond_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // disp_x [31:0], disp_y [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // force_x [47:0], force_y [95:48]
  output logic [1:0]  m_axis_tuser,   // at_cutoff [0], saturated [1]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int DW = sbf_pkg::DATA_W;
  localparam int FW = sbf_pkg::DIFF_W;
  localparam int GW = sbf_pkg::GAIN_W;
  localparam int PW = sbf_pkg::PROD_W;
  localparam int OW = sbf_pkg::FORCE_W;
  localparam int HALF = GW / 2;

  typedef struct packed {
    logic [OW-1:0] val;
    logic          sat;
  } sat_res_t;

  function automatic sat_res_t saturate(input logic [PW-1:0] mag, input logic neg);
    sat_res_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (mag > PW'(sbf_pkg::POS_MAX)) begin
        r.val = sbf_pkg::POS_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = mag[OW-1:0];
      end
    end else begin
      if (mag > PW'(sbf_pkg::NEG_MAG)) begin
        r.val = sbf_pkg::NEG_MAG;
        r.sat = 1'b1;
      end else begin
        r.val = OW'(0) - mag[OW-1:0];
      end
    end
    return r;
  endfunction

  logic                      mode_q;
  logic [DW-1:0]             stiff_q, rest_q, mext_q;
  logic [sbf_pkg::EPS_W-1:0] eps_q;
  logic [63:0]               eps_prod;

  assign cfg_ready_o = 1'b1;
  assign eps_prod    = mext_q * sbf_pkg::EPS_MAGIC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      stiff_q <= sbf_pkg::STIFF_RST;
      rest_q  <= sbf_pkg::REST_RST;
      mext_q  <= sbf_pkg::MEXT_RST;
      eps_q   <= sbf_pkg::EPS_RST;
    end else begin
      eps_q <= eps_prod[sbf_pkg::EPS_SHIFT+sbf_pkg::EPS_W-1:sbf_pkg::EPS_SHIFT];
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sbf_pkg::REG_FORCE_MODE:  mode_q  <= cfg_data_i[0];
          sbf_pkg::REG_STIFFNESS:   stiff_q <= cfg_data_i;
          sbf_pkg::REG_REST_LENGTH: rest_q  <= cfg_data_i;
          sbf_pkg::REG_MAX_EXT:     mext_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic in_vld_q, sq_vld_q, rad_vld_q, pm_vld_q, pc_vld_q, tp_vld_q, gd_vld_q;
  logic kg_vld_q, gn_vld_q, pp_vld_q, pr_vld_q;
  logic [DW-1:0]  in_dx_q, in_dy_q, sq_dx_q, sq_dy_q, rad_dx_q, rad_dy_q;
  logic [63:0]    sqx_q, sqy_q, rad_q;
  logic [DW-1:0]  ax_in, ay_in;

  assign ax_in = in_dx_q[DW-1] ? (~in_dx_q + DW'(1)) : in_dx_q;
  assign ay_in = in_dy_q[DW-1] ? (~in_dy_q + DW'(1)) : in_dy_q;

  logic          len_vld;
  logic [DW-1:0] len;
  logic [63:0]   len_side;
  logic [DW-1:0] len_dx, len_dy, ax_l, ay_l, ext_l;

  sbf_isqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (rad_vld_q),
    .rad_i  (rad_q),
    .side_i ({rad_dy_q, rad_dx_q}),
    .vld_o  (len_vld),
    .root_o (len),
    .side_o (len_side)
  );

  assign len_dx = len_side[DW-1:0];
  assign len_dy = len_side[2*DW-1:DW];
  assign ax_l   = len_dx[DW-1] ? (~len_dx + DW'(1)) : len_dx;
  assign ay_l   = len_dy[DW-1] ? (~len_dy + DW'(1)) : len_dy;
  assign ext_l  = (rest_q > len) ? (rest_q - len) : (len - rest_q);

  logic [63:0]   pm_rax_q, pm_ray_q, pc_rax_q, pc_ray_q;
  logic [DW-1:0] pm_len_q, pm_dx_q, pm_dy_q, pm_ext_q;
  logic [DW-1:0] pc_len_q, pc_dx_q, pc_dy_q, pc_ext_q;
  logic          pc_cut_q;
  logic [DW+1:0] margin;

  assign margin = {2'b00, mext_q} - {2'b00, pm_ext_q};

  logic          dv_vld;
  logic [DW-1:0] qx, qy, qs;
  logic [65:0]   dv_side;

  sbf_div #(.NUM_W(64), .DEN_W(32), .Q_W(32), .SIDE_W(66)) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pc_vld_q),
    .num_i  (pc_rax_q),
    .den_i  (pc_len_q),
    .side_i ({pc_cut_q, (pc_len_q == '0), pc_dy_q, pc_dx_q}),
    .vld_o  (dv_vld),
    .quo_o  (qx),
    .side_o (dv_side)
  );

  sbf_div #(.NUM_W(64), .DEN_W(32), .Q_W(32), .SIDE_W(1)) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pc_vld_q),
    .num_i  (pc_ray_q),
    .den_i  (pc_len_q),
    .side_i (1'b0),
    .vld_o  (),
    .quo_o  (qy),
    .side_o ()
  );

  sbf_div #(.NUM_W(64), .DEN_W(32), .Q_W(32), .SIDE_W(1)) u_div_s (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pc_vld_q),
    .num_i  ({pc_ext_q, 32'd0}),
    .den_i  (mext_q),
    .side_i (1'b0),
    .vld_o  (),
    .quo_o  (qs),
    .side_o ()
  );

  logic [DW-1:0] dv_dx, dv_dy, s_eff;
  logic          dv_lz, dv_cut;
  logic [FW-1:0] tx, ty, dfx, dfy;

  assign dv_dx  = dv_side[DW-1:0];
  assign dv_dy  = dv_side[2*DW-1:DW];
  assign dv_lz  = dv_side[2*DW];
  assign dv_cut = dv_side[2*DW+1];
  assign tx = dv_lz ? {2'b00, rest_q}
            : (dv_dx[DW-1] ? (FW'(0) - {2'b00, qx}) : {2'b00, qx});
  assign ty = dv_lz ? '0
            : (dv_dy[DW-1] ? (FW'(0) - {2'b00, qy}) : {2'b00, qy});
  assign dfx   = {{2{dv_dx[DW-1]}}, dv_dx} - tx;
  assign dfy   = {{2{dv_dy[DW-1]}}, dv_dy} - ty;
  assign s_eff = dv_cut ? sbf_pkg::S_CUT : qs;

  logic [63:0]   tp_ssq_q;
  logic [FW-1:0] tp_dfx_q, tp_dfy_q, gd_dfx_q, gd_dfy_q;
  logic          tp_cut_q, gd_cut_q;
  logic [DW:0]   gd_den_q;

  logic                 g_vld;
  logic [sbf_pkg::G_W-1:0] g;
  logic [2*FW:0]        g_side;

  sbf_div #(.NUM_W(63), .DEN_W(33), .Q_W(36), .SIDE_W(69)) u_div_g (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (gd_vld_q),
    .num_i  (63'd1 << 62),
    .den_i  (gd_den_q),
    .side_i ({gd_cut_q, gd_dfy_q, gd_dfx_q}),
    .vld_o  (g_vld),
    .quo_o  (g),
    .side_o (g_side)
  );

  logic [67:0]   kg_q;
  logic [FW-1:0] kg_dfx_q, kg_dfy_q;
  logic          kg_cut_q;
  logic [GW-1:0] gn_gain_q;
  logic [FW-1:0] gn_dmx_q, gn_dmy_q;
  logic          gn_negx_q, gn_negy_q, gn_cut_q;
  logic [HALF+FW-1:0] pp_lx_q, pp_hx_q, pp_ly_q, pp_hy_q;
  logic          pp_negx_q, pp_negy_q, pp_cut_q;
  logic [PW-1:0] pr_x_q, pr_y_q;
  logic          pr_negx_q, pr_negy_q, pr_cut_q;
  logic [OW-1:0] out_fx_q, out_fy_q;
  logic          out_cut_q, out_sat_q;
  sat_res_t      sat_x, sat_y;

  assign sat_x = saturate(pr_x_q >> FRAC_BITS, pr_negx_q);
  assign sat_y = saturate(pr_y_q >> FRAC_BITS, pr_negy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      rad_vld_q <= 1'b0;
      pm_vld_q  <= 1'b0;
      pc_vld_q  <= 1'b0;
      tp_vld_q  <= 1'b0;
      gd_vld_q  <= 1'b0;
      kg_vld_q  <= 1'b0;
      gn_vld_q  <= 1'b0;
      pp_vld_q  <= 1'b0;
      pr_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= s_axis_tvalid;
      sq_vld_q  <= in_vld_q;
      rad_vld_q <= sq_vld_q;
      pm_vld_q  <= len_vld;
      pc_vld_q  <= pm_vld_q;
      tp_vld_q  <= dv_vld;
      gd_vld_q  <= tp_vld_q;
      kg_vld_q  <= g_vld;
      gn_vld_q  <= kg_vld_q;
      pp_vld_q  <= gn_vld_q;
      pr_vld_q  <= pp_vld_q;
      out_vld_q <= pr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_dx_q  <= s_axis_tdata[DW-1:0];
      in_dy_q  <= s_axis_tdata[2*DW-1:DW];

      sqx_q    <= ax_in * ax_in;
      sqy_q    <= ay_in * ay_in;
      sq_dx_q  <= in_dx_q;
      sq_dy_q  <= in_dy_q;

      rad_q    <= sqx_q + sqy_q;
      rad_dx_q <= sq_dx_q;
      rad_dy_q <= sq_dy_q;

      pm_rax_q <= rest_q * ax_l;
      pm_ray_q <= rest_q * ay_l;
      pm_len_q <= len;
      pm_dx_q  <= len_dx;
      pm_dy_q  <= len_dy;
      pm_ext_q <= ext_l;

      pc_rax_q <= pm_rax_q;
      pc_ray_q <= pm_ray_q;
      pc_len_q <= pm_len_q;
      pc_dx_q  <= pm_dx_q;
      pc_dy_q  <= pm_dy_q;
      pc_ext_q <= pm_ext_q;
      pc_cut_q <= !($signed(margin) > $signed({8'd0, eps_q}));

      tp_ssq_q <= s_eff * s_eff;
      tp_dfx_q <= dfx;
      tp_dfy_q <= dfy;
      tp_cut_q <= dv_cut;

      gd_den_q <= {1'b1, 32'd0} - {1'b0, tp_ssq_q[63:32]};
      gd_dfx_q <= tp_dfx_q;
      gd_dfy_q <= tp_dfy_q;
      gd_cut_q <= tp_cut_q;

      kg_q     <= stiff_q * g;
      kg_dfx_q <= g_side[FW-1:0];
      kg_dfy_q <= g_side[2*FW-1:FW];
      kg_cut_q <= g_side[2*FW];

      gn_gain_q <= mode_q ? kg_q[67:30] : GW'(stiff_q);
      gn_dmx_q  <= kg_dfx_q[FW-1] ? (FW'(0) - kg_dfx_q) : kg_dfx_q;
      gn_dmy_q  <= kg_dfy_q[FW-1] ? (FW'(0) - kg_dfy_q) : kg_dfy_q;
      gn_negx_q <= kg_dfx_q[FW-1];
      gn_negy_q <= kg_dfy_q[FW-1];
      gn_cut_q  <= kg_cut_q && mode_q;

      pp_lx_q   <= gn_gain_q[HALF-1:0] * gn_dmx_q;
      pp_hx_q   <= gn_gain_q[GW-1:HALF] * gn_dmx_q;
      pp_ly_q   <= gn_gain_q[HALF-1:0] * gn_dmy_q;
      pp_hy_q   <= gn_gain_q[GW-1:HALF] * gn_dmy_q;
      pp_negx_q <= gn_negx_q;
      pp_negy_q <= gn_negy_q;
      pp_cut_q  <= gn_cut_q;

      pr_x_q    <= (PW'(pp_hx_q) << HALF) + PW'(pp_lx_q);
      pr_y_q    <= (PW'(pp_hy_q) << HALF) + PW'(pp_ly_q);
      pr_negx_q <= pp_negx_q;
      pr_negy_q <= pp_negy_q;
      pr_cut_q  <= pp_cut_q;

      out_fx_q  <= sat_x.val;
      out_fy_q  <= sat_y.val;
      out_sat_q <= sat_x.sat || sat_y.sat;
      out_cut_q <= pr_cut_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_fy_q, out_fx_q};
  assign m_axis_tuser  = {out_sat_q, out_cut_q};

`ifndef NO_ASSERTIONS
  a_eps_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((40'(eps_q) * 40'd100) <= 40'($past(mext_q)))
          && (40'($past(mext_q)) < ((40'(eps_q) + 40'd1) * 40'd100)))
    else $error("cutoff margin is not one hundredth of max_extension");

  a_gain_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gd_vld_q |-> gd_den_q != '0)
    else $error("FENE gain divisor is zero");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata[47:0] == sbf_pkg::POS_MAX || m_axis_tdata[47:0] == sbf_pkg::NEG_MAG
       || m_axis_tdata[95:48] == sbf_pkg::POS_MAX || m_axis_tdata[95:48] == sbf_pkg::NEG_MAG))
    else $error("saturation flag without a clamped force component");
`endif

endmodule
